@@ hdl/rau_pkg.sv @@
`default_nettype none

package rau_pkg;

	localparam int WORD_BITS_DEF = 32;

	localparam int PC_BITS = 5;
	localparam logic [PC_BITS-1:0] PC_ADDSUB = 5'd0;
	localparam logic [PC_BITS-1:0] PC_MUL = 5'd11;
	localparam logic [PC_BITS-1:0] PC_LAST = 5'd19;

	typedef enum logic [1:0] {
		KIND_ADD = 2'd0,
		KIND_SUB = 2'd1,
		KIND_MUL = 2'd2,
		KIND_DIV = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		R_MA,
		R_MB,
		R_DA,
		R_DB,
		R_T0,
		R_T1,
		R_T2,
		R_T3
	} reg_sel_t;

	typedef enum logic [1:0] {
		SG_A,
		SG_B,
		SG_AB
	} sgn_sel_t;

	typedef enum logic [2:0] {
		I_GCD,
		I_DIV,
		I_MUL_S,
		I_MUL_U,
		I_ADD,
		I_END
	} ins_op_t;

	typedef struct packed {
		ins_op_t  op;
		reg_sel_t src1;
		reg_sel_t src2;
		reg_sel_t dst;
		sgn_sel_t sgn;
	} ins_t;

	typedef enum logic [3:0] {
		CMD_IDLE,
		CMD_LOAD,
		CMD_GCD_INIT,
		CMD_GCD_STEP,
		CMD_GCD_NEXT,
		CMD_GCD_END,
		CMD_DIV_START,
		CMD_DIV_END,
		CMD_MUL,
		CMD_CHK_S,
		CMD_CHK_U,
		CMD_ADD,
		CMD_OUT
	} cmd_op_t;

	typedef struct packed {
		cmd_op_t  op;
		reg_sel_t src1;
		reg_sel_t src2;
		reg_sel_t dst;
		sgn_sel_t sgn;
	} dp_cmd_t;

	typedef struct packed {
		logic div_done;
		logic ga_zero;
	} dp_sts_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FETCH,
		ST_GTEST,
		ST_GWAIT,
		ST_DWAIT,
		ST_CHK,
		ST_OUT
	} ctrl_st_t;

	function automatic ins_t mk(input ins_op_t op, input reg_sel_t s1, input reg_sel_t s2,
			input reg_sel_t d, input sgn_sel_t sg);
		ins_t r;
		r.op = op;
		r.src1 = s1;
		r.src2 = s2;
		r.dst = d;
		r.sgn = sg;
		return r;
	endfunction

	// add/sub program first, multiply/divide program from PC_MUL
	function automatic ins_t prog(input logic [PC_BITS-1:0] pc);
		ins_t r;
		unique case (pc)
			5'd0:  r = mk(I_GCD,   R_DA, R_DB, R_T0, SG_A);
			5'd1:  r = mk(I_DIV,   R_DB, R_T0, R_T1, SG_A);
			5'd2:  r = mk(I_DIV,   R_DA, R_T0, R_T2, SG_A);
			5'd3:  r = mk(I_MUL_S, R_MA, R_T1, R_T3, SG_A);
			5'd4:  r = mk(I_MUL_S, R_MB, R_T2, R_T0, SG_B);
			5'd5:  r = mk(I_MUL_U, R_DA, R_T1, R_T2, SG_A);
			5'd6:  r = mk(I_ADD,   R_T3, R_T0, R_T1, SG_A);
			5'd7:  r = mk(I_GCD,   R_T1, R_T2, R_T0, SG_A);
			5'd8:  r = mk(I_DIV,   R_T1, R_T0, R_MA, SG_A);
			5'd9:  r = mk(I_DIV,   R_T2, R_T0, R_DA, SG_A);
			5'd10: r = mk(I_END,   R_MA, R_MA, R_MA, SG_A);
			5'd11: r = mk(I_GCD,   R_DA, R_MB, R_T0, SG_A);
			5'd12: r = mk(I_GCD,   R_DB, R_MA, R_T1, SG_A);
			5'd13: r = mk(I_DIV,   R_MA, R_T1, R_T2, SG_A);
			5'd14: r = mk(I_DIV,   R_MB, R_T0, R_T3, SG_A);
			5'd15: r = mk(I_MUL_S, R_T2, R_T3, R_MA, SG_AB);
			5'd16: r = mk(I_DIV,   R_DA, R_T0, R_T2, SG_A);
			5'd17: r = mk(I_DIV,   R_DB, R_T1, R_T3, SG_A);
			5'd18: r = mk(I_MUL_U, R_T2, R_T3, R_DA, SG_A);
			default: r = mk(I_END, R_MA, R_MA, R_MA, SG_A);
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

@@ hdl/rational_arith_unit_top.sv @@
// channel | handshake                     | payload
// req     | req_valid / req_stall         | kind, num_a, den_a, num_b, den_b
// rsp     | rsp_valid / rsp_stall         | num_r, den_r, error
//
// One item at a time. Each Euclid step and each exact division runs the
// radix-2 divider. arst_n clears the controller; the block is idle after
// reset. A waiting result is held in the output register; the next item
// is taken meanwhile and holds in its final state until the output
// register frees.
`default_nettype none

module rational_arith_unit_top import rau_pkg::*; #(
	parameter int WORD_BITS = WORD_BITS_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        req_valid,
	output logic                             req_stall,
	input  wire logic [1:0]                  kind,
	input  wire logic signed [WORD_BITS-1:0] num_a,
	input  wire logic [WORD_BITS-1:0]        den_a,
	input  wire logic signed [WORD_BITS-1:0] num_b,
	input  wire logic [WORD_BITS-1:0]        den_b,
	output logic                             rsp_valid,
	input  wire logic                        rsp_stall,
	output logic signed [WORD_BITS-1:0]      num_r,
	output logic [WORD_BITS-1:0]             den_r,
	output logic                             error
);

	dp_cmd_t cmd;
	dp_sts_t sts;

	rau_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.is_mul(kind[1]),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.sts(sts),
		.cmd(cmd)
	);

	rau_dp #(.W(WORD_BITS)) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.sts(sts),
		.kind(kind),
		.num_a(num_a),
		.den_a(den_a),
		.num_b(num_b),
		.den_b(den_b),
		.num_r(num_r),
		.den_r(den_r),
		.error(error)
	);

endmodule

`default_nettype wire

@@ hdl/rau_div.sv @@
`default_nettype none

module rau_div import rau_pkg::*; #(
	parameter int W = WORD_BITS_DEF
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         start,
	input  wire logic [W-1:0] dividend,
	input  wire logic [W-1:0] divisor,
	output logic [W-1:0]      quo,
	output logic [W-1:0]      rem,
	output logic              done
);

	localparam int CW = $clog2(W + 1);

	logic          busy_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [W-1:0]  quo_q;
	logic [W-1:0]  rem_q;
	logic [W-1:0]  dvs_q;
	logic [W:0]    shifted;
	logic [W:0]    diff;
	logic          ge;

	always_comb begin
		shifted = {rem_q, quo_q[W-1]};
		diff = shifted - {1'b0, dvs_q};
		ge = shifted >= {1'b0, dvs_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == CW'(1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= CW'(W);
			end else if (busy_q) begin
				busy_q <= cnt_q != CW'(1);
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[W-2:0], ge};
			rem_q <= ge ? diff[W-1:0] : shifted[W-1:0];
		end
	end

	assign quo = quo_q;
	assign rem = rem_q;
	assign done = done_q;

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !busy_q) else $error("divider done while busy");

endmodule

`default_nettype wire

@@ hdl/rau_dp.sv @@
`default_nettype none

module rau_dp import rau_pkg::*; #(
	parameter int W = WORD_BITS_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire dp_cmd_t             cmd,
	output dp_sts_t                  sts,
	input  wire logic [1:0]          kind,
	input  wire logic signed [W-1:0] num_a,
	input  wire logic [W-1:0]        den_a,
	input  wire logic signed [W-1:0] num_b,
	input  wire logic [W-1:0]        den_b,
	output logic signed [W-1:0]      num_r,
	output logic [W-1:0]             den_r,
	output logic                     error
);

	localparam int AW = W + 2;

	logic [W-1:0]    ma_q, mb_q, da_q, db_q, t0_q, t1_q, t2_q, t3_q;
	logic [W-1:0]    ga_q, gb_q;
	logic            sa_q, sb_q, sn_q, sub_q, err_q;
	logic [2*W-1:0]  prod_q;
	logic [W-1:0]    num_r_q, den_r_q;
	logic            error_q;

	logic [W-1:0]    src1v, src2v, wdata;
	logic            wr_en, chk_ok, sgn;
	logic [W-1:0]    na_u, nb_u, na_mag, nb_mag;
	logic [W-1:0]    div_a, div_b, div_quo, div_rem;
	logic            div_start, div_done;
	logic [2*W-1:0]  mul_full;
	logic [AW-1:0]   v1, v2, sum_n, sum_mag;
	logic            hi_zero;

	function automatic logic [W-1:0] rd(input reg_sel_t s, input logic [W-1:0] ma,
			input logic [W-1:0] mb, input logic [W-1:0] da, input logic [W-1:0] db,
			input logic [W-1:0] t0, input logic [W-1:0] t1, input logic [W-1:0] t2,
			input logic [W-1:0] t3);
		logic [W-1:0] r;
		unique case (s)
			R_MA: r = ma;
			R_MB: r = mb;
			R_DA: r = da;
			R_DB: r = db;
			R_T0: r = t0;
			R_T1: r = t1;
			R_T2: r = t2;
			R_T3: r = t3;
			default: r = ma;
		endcase
		return r;
	endfunction

	rau_div #(.W(W)) u_div (
		.clk(clk),
		.arst_n(arst_n),
		.start(div_start),
		.dividend(div_a),
		.divisor(div_b),
		.quo(div_quo),
		.rem(div_rem),
		.done(div_done)
	);

	always_comb begin
		na_u = num_a;
		nb_u = num_b;
		na_mag = na_u[W-1] ? (~na_u + 1'b1) : na_u;
		nb_mag = nb_u[W-1] ? (~nb_u + 1'b1) : nb_u;

		src1v = rd(cmd.src1, ma_q, mb_q, da_q, db_q, t0_q, t1_q, t2_q, t3_q);
		src2v = rd(cmd.src2, ma_q, mb_q, da_q, db_q, t0_q, t1_q, t2_q, t3_q);

		div_start = (cmd.op == CMD_GCD_STEP) || (cmd.op == CMD_DIV_START);
		div_a = (cmd.op == CMD_GCD_STEP) ? gb_q : src1v;
		div_b = (cmd.op == CMD_GCD_STEP) ? ga_q : src2v;

		mul_full = {{W{1'b0}}, src1v} * {{W{1'b0}}, src2v};

		unique case (cmd.sgn)
			SG_A:    sgn = sa_q;
			SG_B:    sgn = sb_q;
			SG_AB:   sgn = sa_q ^ sb_q;
			default: sgn = sa_q;
		endcase

		hi_zero = prod_q[2*W-1:W] == '0;

		v1 = sa_q ? -{2'b00, src1v} : {2'b00, src1v};
		v2 = sb_q ? -{2'b00, src2v} : {2'b00, src2v};
		sum_n = sub_q ? (v1 - v2) : (v1 + v2);
		sum_mag = sum_n[AW-1] ? -sum_n : sum_n;

		wr_en = 1'b0;
		wdata = prod_q[W-1:0];
		chk_ok = 1'b1;
		unique case (cmd.op)
			CMD_GCD_END: begin
				wr_en = 1'b1;
				wdata = (gb_q == '0) ? W'(1) : gb_q;
			end
			CMD_DIV_END: begin
				wr_en = 1'b1;
				wdata = div_quo;
			end
			CMD_CHK_S: begin
				wr_en = 1'b1;
				chk_ok = hi_zero && (!prod_q[W-1] ||
					(sgn && (prod_q[W-1:0] == {1'b1, {(W-1){1'b0}}})));
			end
			CMD_CHK_U: begin
				wr_en = 1'b1;
				chk_ok = hi_zero;
			end
			CMD_ADD: begin
				wr_en = 1'b1;
				wdata = sum_mag[W-1:0];
				chk_ok = (&sum_n[AW-1:W-1]) || !(|sum_n[AW-1:W-1]);
			end
			default: begin
				wr_en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.op == CMD_LOAD) begin
			ma_q <= na_mag;
			sa_q <= na_u[W-1];
			da_q <= den_a;
			sb_q <= nb_u[W-1];
			sub_q <= kind == KIND_SUB;
			if (kind == KIND_DIV) begin
				mb_q <= den_b;
				db_q <= nb_mag;
			end else begin
				mb_q <= nb_mag;
				db_q <= den_b;
			end
		end else if (wr_en) begin
			unique case (cmd.dst)
				R_MA: ma_q <= wdata;
				R_MB: mb_q <= wdata;
				R_DA: da_q <= wdata;
				R_DB: db_q <= wdata;
				R_T0: t0_q <= wdata;
				R_T1: t1_q <= wdata;
				R_T2: t2_q <= wdata;
				R_T3: t3_q <= wdata;
				default: t0_q <= wdata;
			endcase
		end

		if (cmd.op == CMD_GCD_INIT) begin
			ga_q <= src1v;
			gb_q <= src2v;
		end else if (cmd.op == CMD_GCD_NEXT) begin
			ga_q <= div_rem;
			gb_q <= ga_q;
		end

		if (cmd.op == CMD_MUL) begin
			prod_q <= mul_full;
		end

		if (cmd.op == CMD_CHK_S) begin
			sn_q <= sgn;
		end else if (cmd.op == CMD_ADD) begin
			sn_q <= sum_n[AW-1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			err_q <= 1'b0;
			error_q <= 1'b0;
		end else begin
			if (cmd.op == CMD_LOAD) begin
				err_q <= (kind == KIND_DIV) && ((nb_u == '0) || den_b[W-1]);
			end else if (!chk_ok) begin
				err_q <= 1'b1;
			end
			if (cmd.op == CMD_OUT) begin
				error_q <= err_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.op == CMD_OUT) begin
			num_r_q <= err_q ? '0 : (sn_q ? (~ma_q + 1'b1) : ma_q);
			den_r_q <= err_q ? '0 : da_q;
		end
	end

	assign sts.div_done = div_done;
	assign sts.ga_zero = ga_q == '0;
	assign num_r = num_r_q;
	assign den_r = den_r_q;
	assign error = error_q;

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == CMD_OUT) && err_q |=> (num_r_q == '0) && (den_r_q == '0) && error_q)
		else $error("error result not zeroed");

	a_gcd_div: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == CMD_GCD_STEP) |-> (ga_q != '0)) else $error("gcd step on zero");

endmodule

`default_nettype wire

@@ hdl/rau_ctrl.sv @@
`default_nettype none

module rau_ctrl import rau_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    req_valid,
	output logic         req_stall,
	input  wire logic    is_mul,
	output logic         rsp_valid,
	input  wire logic    rsp_stall,
	input  wire dp_sts_t sts,
	output dp_cmd_t      cmd
);

	ctrl_st_t           state_q, state_nx;
	logic [PC_BITS-1:0] pc_q;
	logic               rsp_valid_q;
	logic               slot_free, accept, pc_inc;
	ins_t               ins;

	always_comb begin
		ins = prog(pc_q);
		slot_free = !rsp_valid_q || !rsp_stall;
		accept = (state_q == ST_IDLE) && req_valid;
	end

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ST_IDLE:  if (req_valid) state_nx = ST_FETCH;
			ST_FETCH: begin
				unique case (ins.op)
					I_GCD:            state_nx = ST_GTEST;
					I_DIV:            state_nx = ST_DWAIT;
					I_MUL_S, I_MUL_U: state_nx = ST_CHK;
					I_ADD:            state_nx = ST_FETCH;
					default:          state_nx = ST_OUT;
				endcase
			end
			ST_GTEST: state_nx = sts.ga_zero ? ST_FETCH : ST_GWAIT;
			ST_GWAIT: if (sts.div_done) state_nx = ST_GTEST;
			ST_DWAIT: if (sts.div_done) state_nx = ST_FETCH;
			ST_CHK:   state_nx = ST_FETCH;
			ST_OUT:   if (slot_free) state_nx = ST_IDLE;
			default:  state_nx = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd.op = CMD_IDLE;
		cmd.src1 = ins.src1;
		cmd.src2 = ins.src2;
		cmd.dst = ins.dst;
		cmd.sgn = ins.sgn;
		pc_inc = 1'b0;
		unique case (state_q)
			ST_IDLE: if (accept) cmd.op = CMD_LOAD;
			ST_FETCH: begin
				unique case (ins.op)
					I_GCD:            cmd.op = CMD_GCD_INIT;
					I_DIV:            cmd.op = CMD_DIV_START;
					I_MUL_S, I_MUL_U: cmd.op = CMD_MUL;
					I_ADD: begin
						cmd.op = CMD_ADD;
						pc_inc = 1'b1;
					end
					default:          cmd.op = CMD_IDLE;
				endcase
			end
			ST_GTEST: begin
				cmd.op = sts.ga_zero ? CMD_GCD_END : CMD_GCD_STEP;
				pc_inc = sts.ga_zero;
			end
			ST_GWAIT: if (sts.div_done) cmd.op = CMD_GCD_NEXT;
			ST_DWAIT: begin
				if (sts.div_done) begin
					cmd.op = CMD_DIV_END;
					pc_inc = 1'b1;
				end
			end
			ST_CHK: begin
				cmd.op = (ins.op == I_MUL_S) ? CMD_CHK_S : CMD_CHK_U;
				pc_inc = 1'b1;
			end
			ST_OUT: if (slot_free) cmd.op = CMD_OUT;
			default: cmd.op = CMD_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pc_q <= PC_ADDSUB;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (accept) begin
				pc_q <= is_mul ? PC_MUL : PC_ADDSUB;
			end else if (pc_inc) begin
				pc_q <= pc_q + 1'b1;
			end
			if ((state_q == ST_OUT) && slot_free) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign req_stall = state_q != ST_IDLE;
	assign rsp_valid = rsp_valid_q;

	a_pc_range: assert property (@(posedge clk) disable iff (!arst_n)
		pc_q <= PC_LAST) else $error("program counter out of range");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_OUT) && !slot_free |=> (state_q == ST_OUT))
		else $error("result slot overwritten");

	a_busy_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DWAIT) || (state_q == ST_GWAIT) |-> req_stall)
		else $error("item taken during division");

endmodule

`default_nettype wire
